// ===== src/depb_pkg.sv =====
package depb_pkg;

	localparam int CFG_AW   = 5;
	localparam int CFG_DW   = 32;
	localparam int CENTER_W = 16;
	localparam int FOCAL_W  = 18;
	localparam int BAND_W   = 16;
	localparam int X_W      = 25;
	localparam int Y_W      = 17;
	localparam int Z_W      = 16;
	localparam int GRAY_W   = 8;

	localparam logic [CENTER_W-1:0] CENTER_X_RST = 16'd5112;
	localparam logic [CENTER_W-1:0] CENTER_Y_RST = 16'd3832;
	localparam logic [FOCAL_W-1:0]  FOCAL_X_RST  = 18'd8400;
	localparam logic [FOCAL_W-1:0]  FOCAL_Y_RST  = 18'd8400;
	localparam logic [BAND_W-1:0]   BAND_RST     = 16'd100;

	localparam logic [63:0] X_POS_LIM = 64'd16777215;
	localparam logic [63:0] X_NEG_LIM = 64'd16777216;

	typedef enum logic [2:0] {
		REG_CENTER_X = 3'd0,
		REG_CENTER_Y = 3'd1,
		REG_FOCAL_X  = 3'd2,
		REG_FOCAL_Y  = 3'd3,
		REG_BAND     = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic              nz;
		logic              neg_x;
		logic              neg_y;
		logic [Z_W-1:0]    depth;
		logic [GRAY_W-1:0] gray;
	} side_t;

endpackage

// ===== src/depb_if.sv =====
interface pix_if #(parameter int CW = 12, parameter int DW = 16);
	logic          valid;
	logic          ready;
	logic [CW-1:0] pixel_row;
	logic [CW-1:0] pixel_col;
	logic [DW-1:0] depth_mm;
	logic [7:0]    intensity;

	modport source (output valid, pixel_row, pixel_col, depth_mm, intensity, input ready);
	modport sink (input valid, pixel_row, pixel_col, depth_mm, intensity, output ready);
endinterface

interface pt_if;
	logic               valid;
	logic               ready;
	logic signed [24:0] x_mm;
	logic signed [16:0] y_mm;
	logic [15:0]        z_mm;
	logic [7:0]         gray;

	modport source (output valid, x_mm, y_mm, z_mm, gray, input ready);
	modport sink (input valid, x_mm, y_mm, z_mm, gray, output ready);
endinterface

// ===== src/depth_pixel_backprojection.sv =====
// throughput: one pixel per cycle while the output is not stalled
// two restoring dividers, one quotient bit per stage
// the whole pipeline holds while a point waits at the output
// pixels with zero depth or outside the band leave no point
// reset: asynchronous active-low arst_n clears valid bits and loads register defaults
module depth_pixel_backprojection import depb_pkg::*; #(
	parameter int COORD_BITS = 12,
	parameter int DEPTH_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [CFG_DW-1:0] pwdata,
	output logic [CFG_DW-1:0] prdata,
	output logic              pready,
	pix_if.sink               pixel,
	pt_if.source              point
);

	localparam int MAG_W = (COORD_BITS + 4 > 16) ? COORD_BITS + 4 : 16;
	localparam int OFF_W = MAG_W + 1;
	localparam int PW    = MAG_W + DEPTH_BITS;
	localparam int RW    = FOCAL_W;

	localparam logic [15:0]    COORD_MASK = 16'((32'd1 << COORD_BITS) - 32'd1);
	localparam logic [Z_W-1:0] DEPTH_MASK = Z_W'((32'd1 << DEPTH_BITS) - 32'd1);

	logic [CENTER_W-1:0] center_x_q, center_y_q;
	logic [FOCAL_W-1:0]  focal_x_q, focal_y_q;
	logic [BAND_W-1:0]   band_q;
	logic                wr_en;
	reg_idx_t            ridx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign ridx   = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= CENTER_X_RST;
			center_y_q <= CENTER_Y_RST;
			focal_x_q  <= FOCAL_X_RST;
			focal_y_q  <= FOCAL_Y_RST;
			band_q     <= BAND_RST;
		end else if (wr_en) begin
			case (ridx)
				REG_CENTER_X: center_x_q <= pwdata[CENTER_W-1:0];
				REG_CENTER_Y: center_y_q <= pwdata[CENTER_W-1:0];
				REG_FOCAL_X:  focal_x_q  <= pwdata[FOCAL_W-1:0];
				REG_FOCAL_Y:  focal_y_q  <= pwdata[FOCAL_W-1:0];
				REG_BAND:     band_q     <= pwdata[BAND_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (ridx)
			REG_CENTER_X: prdata = CFG_DW'(center_x_q);
			REG_CENTER_Y: prdata = CFG_DW'(center_y_q);
			REG_FOCAL_X:  prdata = CFG_DW'(focal_x_q);
			REG_FOCAL_Y:  prdata = CFG_DW'(focal_y_q);
			REG_BAND:     prdata = CFG_DW'(band_q);
			default:      prdata = '0;
		endcase
	end

	logic [RW-1:0] den_x, den_y;
	assign den_x = (focal_x_q == '0) ? RW'(1) : focal_x_q;
	assign den_y = (focal_y_q == '0) ? RW'(1) : focal_y_q;

	logic advance, out_valid_q;
	assign advance     = !out_valid_q || point.ready;
	assign pixel.ready = advance;

	// stage 1: offsets from principal point
	logic [15:0]      col_c, row_c;
	logic [Z_W-1:0]   depth_c;
	logic [OFF_W-1:0] off_x_c, off_y_c;
	logic [OFF_W-1:0] off_x_s1, off_y_s1;
	side_t            side_s1;
	logic             valid_s1;

	assign col_c   = 16'(pixel.pixel_col) & COORD_MASK;
	assign row_c   = 16'(pixel.pixel_row) & COORD_MASK;
	assign depth_c = Z_W'(pixel.depth_mm) & DEPTH_MASK;

	assign off_x_c = (OFF_W'(col_c) << 4) - OFF_W'(center_x_q);
	assign off_y_c = (OFF_W'(row_c) << 4) - OFF_W'(center_y_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else if (advance) valid_s1 <= pixel.valid;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			off_x_s1      <= off_x_c;
			off_y_s1      <= off_y_c;
			side_s1.nz    <= (depth_c != '0);
			side_s1.neg_x <= off_x_c[OFF_W-1];
			side_s1.neg_y <= off_y_c[OFF_W-1];
			side_s1.depth <= depth_c;
			side_s1.gray  <= pixel.intensity;
		end
	end

	// stage 2: magnitude times depth
	logic [MAG_W-1:0] mag_x, mag_y;
	assign mag_x = off_x_s1[OFF_W-1] ? MAG_W'(-off_x_s1) : MAG_W'(off_x_s1);
	assign mag_y = off_y_s1[OFF_W-1] ? MAG_W'(-off_y_s1) : MAG_W'(off_y_s1);

	logic [PW-1:0] num_x_sd [PW+1];
	logic [PW-1:0] num_y_sd [PW+1];
	logic [PW-1:0] quo_x_sd [PW+1];
	logic [PW-1:0] quo_y_sd [PW+1];
	logic [RW-1:0] rem_x_sd [PW+1];
	logic [RW-1:0] rem_y_sd [PW+1];
	side_t         side_sd  [PW+1];
	logic          valid_sd [PW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_sd[0] <= 1'b0;
		else if (advance) valid_sd[0] <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			num_x_sd[0] <= PW'(mag_x) * PW'(side_s1.depth[DEPTH_BITS-1:0]);
			num_y_sd[0] <= PW'(mag_y) * PW'(side_s1.depth[DEPTH_BITS-1:0]);
			quo_x_sd[0] <= '0;
			quo_y_sd[0] <= '0;
			rem_x_sd[0] <= '0;
			rem_y_sd[0] <= '0;
			side_sd[0]  <= side_s1;
		end
	end

	// restoring division, one quotient bit per stage
	for (genvar k = 0; k < PW; k++) begin : g_div
		logic [RW:0] trial_x, trial_y;
		logic        ge_x, ge_y;

		assign trial_x = {rem_x_sd[k], num_x_sd[k][PW-1]};
		assign trial_y = {rem_y_sd[k], num_y_sd[k][PW-1]};
		assign ge_x    = trial_x >= {1'b0, den_x};
		assign ge_y    = trial_y >= {1'b0, den_y};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) valid_sd[k+1] <= 1'b0;
			else if (advance) valid_sd[k+1] <= valid_sd[k];
		end

		always_ff @(posedge clk) begin
			if (advance) begin
				rem_x_sd[k+1] <= ge_x ? RW'(trial_x - {1'b0, den_x}) : RW'(trial_x);
				rem_y_sd[k+1] <= ge_y ? RW'(trial_y - {1'b0, den_y}) : RW'(trial_y);
				num_x_sd[k+1] <= num_x_sd[k] << 1;
				num_y_sd[k+1] <= num_y_sd[k] << 1;
				quo_x_sd[k+1] <= {quo_x_sd[k][PW-2:0], ge_x};
				quo_y_sd[k+1] <= {quo_y_sd[k][PW-2:0], ge_y};
				side_sd[k+1]  <= side_sd[k];
			end
		end
	end

	// output stage: sign, saturation and band test
	side_t             sd_last;
	logic [PW-1:0]     qx, qy;
	logic              keep;
	logic [X_W-1:0]    xv, x_res;
	logic [Y_W-1:0]    yv, y_res;

	assign sd_last = side_sd[PW];
	assign qx      = quo_x_sd[PW];
	assign qy      = quo_y_sd[PW];
	assign keep    = sd_last.nz && (64'(qy) < 64'(band_q));
	assign xv      = X_W'(qx);
	assign yv      = Y_W'(qy);
	assign y_res   = sd_last.neg_y ? -yv : yv;

	always_comb begin
		if (sd_last.neg_x) begin
			x_res = (64'(qx) > X_NEG_LIM) ? X_W'(X_NEG_LIM) : -xv;
			if (64'(qx) > X_NEG_LIM) x_res = {1'b1, {(X_W-1){1'b0}}};
		end else begin
			x_res = (64'(qx) > X_POS_LIM) ? X_W'(X_POS_LIM) : xv;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (advance) out_valid_q <= valid_sd[PW] && keep;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			point.x_mm <= x_res;
			point.y_mm <= y_res;
			point.z_mm <= sd_last.depth;
			point.gray <= sd_last.gray;
		end
	end

	assign point.valid = out_valid_q;

endmodule

// ===== src/depb_checker.sv =====
module depb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        pready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [16:0] y_mm,
	input logic [15:0] z_mm,
	input logic [24:0] x_mm
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(x_mm) && $stable(y_mm))
		else $error("point dropped while stalled");

	a_z_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> z_mm != 16'd0)
		else $error("point with zero depth");

	a_y_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> y_mm != 17'h10000)
		else $error("y outside band");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind depth_pixel_backprojection depb_checker u_depb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.pready    (pready),
	.out_valid (point.valid),
	.out_ready (point.ready),
	.y_mm      (point.y_mm),
	.z_mm      (point.z_mm),
	.x_mm      (point.x_mm)
);

// ===== bench/tb_depth_pixel_backprojection.sv =====
`timescale 1ns / 100ps

module tb_depth_pixel_backprojection;
	import depb_pkg::*;

	localparam int LATENCY = 12 + 16 + 7;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		logic [11:0] row;
		logic [11:0] col;
		logic [15:0] depth;
		logic [7:0]  intensity;
	} pixel_t;

	typedef struct {
		logic signed [24:0] x;
		logic signed [16:0] y;
		logic [15:0]        z;
		logic [7:0]         gray;
	} point_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [CFG_AW-1:0] paddr = '0;
	logic [CFG_DW-1:0] pwdata = '0;
	logic [CFG_DW-1:0] prdata;
	logic pready;

	pix_if #(.CW(12), .DW(16)) pixel ();
	pt_if point ();

	depth_pixel_backprojection u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.pixel(pixel.sink), .point(point.source)
	);

	always #5 clk = ~clk;

	logic [15:0] cam_cx, cam_cy, cam_band;
	logic [17:0] cam_fx, cam_fy;

	pixel_t pending_pixels[$];
	point_t expected_points[$];
	int errors = 0;
	int cycles = 0;
	bit driver_on = 1'b0;
	bit gap_on = 1'b1;
	int burst_left = 0;
	int gap_left = 0;
	int stall_phase = 0;

	function automatic longint unsigned_div_proj(longint coord, longint center, longint depth,
		longint focal);
		longint off, den;
		off = coord * 16 - center;
		den = (focal == 0) ? 1 : focal;
		return (off * depth) / den;
	endfunction

	task automatic predict_point(input pixel_t p);
		longint x, y, ay;
		point_t e;
		if (p.depth == 0) return;
		x = unsigned_div_proj(p.col, cam_cx, p.depth, cam_fx);
		y = unsigned_div_proj(p.row, cam_cy, p.depth, cam_fy);
		ay = (y < 0) ? -y : y;
		if (!(ay < cam_band)) return;
		if (x > 16777215) x = 16777215;
		if (x < -16777216) x = -16777216;
		e.x = x[24:0];
		e.y = y[16:0];
		e.z = p.depth;
		e.gray = p.intensity;
		expected_points = {expected_points, e};
	endtask

	// driver
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (pixel.valid && pixel.ready) begin
			predict_point(pending_pixels.pop_front());
		end
		if (!(pixel.valid && !pixel.ready)) begin
			if (driver_on && pending_pixels.size() > 0 && !(pixel.valid && pixel.ready
				&& pending_pixels.size() == 0)) begin
				if (burst_left > 0) begin
					burst_left <= burst_left - 1;
					pixel.valid <= 1'b1;
					pixel.pixel_row <= pending_pixels[0].row;
					pixel.pixel_col <= pending_pixels[0].col;
					pixel.depth_mm <= pending_pixels[0].depth;
					pixel.intensity <= pending_pixels[0].intensity;
				end else if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					pixel.valid <= 1'b0;
				end else begin
					pixel.valid <= 1'b0;
					burst_left <= $urandom_range(1, 40);
					gap_left <= gap_on ? $urandom_range(0, 6) : 0;
				end
			end else begin
				pixel.valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		point_t e;
		if (point.valid && point.ready) begin
			if (expected_points.size() == 0) begin
				$error("unexpected point x=%0d y=%0d", point.x_mm, point.y_mm);
				errors = errors + 1;
			end else begin
				e = expected_points.pop_front();
				if (point.x_mm !== e.x) begin
					$error("x_mm expected %0d actual %0d", e.x, point.x_mm);
					errors = errors + 1;
				end
				if (point.y_mm !== e.y) begin
					$error("y_mm expected %0d actual %0d", e.y, point.y_mm);
					errors = errors + 1;
				end
				if (point.z_mm !== e.z) begin
					$error("z_mm expected %0d actual %0d", e.z, point.z_mm);
					errors = errors + 1;
				end
				if (point.gray !== e.gray) begin
					$error("gray expected %0d actual %0d", e.gray, point.gray);
					errors = errors + 1;
				end
			end
		end
		stall_phase <= stall_phase + 1;
		if (stall_phase % 512 < 128) point.ready <= 1'b1;
		else if (stall_phase % 7 == 3) point.ready <= 1'b0;
		else point.ready <= ($urandom_range(0, 3) != 0);
	end

	always @(posedge clk) begin
		if (cycles >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CFG_AW'(idx) << 2;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_CENTER_X: cam_cx = value[15:0];
			REG_CENTER_Y: cam_cy = value[15:0];
			REG_FOCAL_X:  cam_fx = value[17:0];
			REG_FOCAL_Y:  cam_fy = value[17:0];
			REG_BAND:     cam_band = value[15:0];
			default: ;
		endcase
	endtask

	task automatic drain_all();
		driver_on = 1'b1;
		wait (pending_pixels.size() == 0);
		@(posedge clk);
		wait (!pixel.valid && expected_points.size() == 0);
		repeat (LATENCY + 5) @(posedge clk);
		wait (expected_points.size() == 0);
		driver_on = 1'b0;
		@(posedge clk);
	endtask

	task automatic add_pixel(input int row, input int col, input int depth, input int gray);
		pixel_t p;
		p.row = 12'(row);
		p.col = 12'(col);
		p.depth = 16'(depth);
		p.intensity = 8'(gray);
		pending_pixels = {pending_pixels, p};
	endtask

	task automatic add_random(input int n, input int band_rows);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 9);
			if (r < 6) begin
				// rows near the principal point so the band test passes often
				add_pixel(int'(cam_cy >> 4) + $urandom_range(0, 2 * band_rows) - band_rows,
					$urandom_range(0, 4095), $urandom_range(1, 65535), $urandom_range(0, 255));
			end else if (r < 7) begin
				add_pixel($urandom_range(0, 4095), $urandom_range(0, 4095), 0,
					$urandom_range(0, 255));
			end else begin
				add_pixel($urandom_range(0, 4095), $urandom_range(0, 4095),
					$urandom_range(0, 65535), $urandom_range(0, 255));
			end
		end
	endtask

	initial begin
		pixel.valid = 1'b0;
		pixel.pixel_row = '0;
		pixel.pixel_col = '0;
		pixel.depth_mm = '0;
		pixel.intensity = '0;
		point.ready = 1'b0;
		cam_cx = CENTER_X_RST;
		cam_cy = CENTER_Y_RST;
		cam_fx = FOCAL_X_RST;
		cam_fy = FOCAL_Y_RST;
		cam_band = BAND_RST;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset intrinsics
		add_pixel(239, 319, 1000, 8'h5a);
		add_pixel(239, 0, 65535, 8'hff);
		add_pixel(239, 4095, 65535, 8'h00);
		add_pixel(240, 319, 0, 8'h11);
		add_pixel(0, 0, 65535, 8'h22);
		add_pixel(4095, 4095, 1, 8'h33);
		add_pixel(245, 100, 500, 8'ha5);
		add_random(200, 3);
		drain_all();

		// saturation of x, zero focal lengths, wide band
		write_reg(REG_CENTER_X, 32'h0000_0000);
		write_reg(REG_CENTER_Y, 32'h0000_ffff);
		write_reg(REG_FOCAL_X, 32'h0000_0000);
		write_reg(REG_FOCAL_Y, 32'h0000_0000);
		write_reg(REG_BAND, 32'h0000_ffff);
		add_pixel(4095, 4095, 65535, 8'h01);
		add_pixel(4095, 0, 65535, 8'h02);
		add_pixel(4095, 4095, 1, 8'h03);
		add_pixel(4094, 2048, 7, 8'h04);
		add_random(150, 2);
		drain_all();

		write_reg(REG_CENTER_X, 32'h0000_ffff);
		write_reg(REG_FOCAL_X, 32'h0000_0001);
		write_reg(REG_FOCAL_Y, 32'h0003_ffff);
		add_pixel(0, 0, 65535, 8'h05);
		add_pixel(0, 4095, 65535, 8'h06);
		add_random(150, 400);
		drain_all();

		// zero band and minimum band
		write_reg(REG_BAND, 32'h0000_0000);
		add_pixel(2048, 2048, 100, 8'h07);
		add_random(50, 4);
		drain_all();
		write_reg(REG_BAND, 32'h0000_0001);
		write_reg(REG_FOCAL_Y, 32'h0000_0100);
		write_reg(REG_CENTER_Y, 32'h0000_8000);
		write_reg(REG_FOCAL_X, 32'h0000_0100);
		add_pixel(2048, 10, 65535, 8'h08);
		add_random(150, 1);
		drain_all();

		for (int phase = 0; phase < 4; phase++) begin
			write_reg(REG_CENTER_X, $urandom_range(0, 65535));
			write_reg(REG_CENTER_Y, $urandom_range(0, 65535));
			write_reg(REG_FOCAL_X, $urandom_range(256, 262143));
			write_reg(REG_FOCAL_Y, $urandom_range(256, 8400));
			write_reg(REG_BAND, $urandom_range(1, 65535));
			gap_on = (phase != 2);
			add_random(200, 20);
			drain_all();
		end

		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
src/depb_pkg.sv
src/depb_if.sv
src/depth_pixel_backprojection.sv
src/depb_checker.sv
bench/tb_depth_pixel_backprojection.sv
